// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// full property, sampled on clk_i, off while rst_ni is low
`define FCOND_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define FCOND_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fcond_pkg.sv -----
// ----------------------------------------------------------------------------
// fcond_pkg
// shared types, widths and constants of the controller frame conditioner
// ----------------------------------------------------------------------------
package fcond_pkg;

  localparam int unsigned StickW   = 10;
  localparam int unsigned AccelW   = 16;
  localparam int unsigned PtrW     = 12;
  localparam int unsigned ButtonsW = 16;
  localparam int unsigned IdleW    = 18;
  localparam int unsigned LimitW   = 26;
  localparam int unsigned MarginW  = 15;
  localparam int unsigned FramesW  = 8;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned NumPtr   = 2;

  // squares of the frame-to-frame change
  localparam int unsigned AccSqW = 2 * (AccelW + 1) - 2;  // |d| < 2^16
  localparam int unsigned PtrSqW = 2 * (PtrW + 1) - 2;    // |d| < 2^12

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 26;

  // stick threshold, half scale in Q.8
  localparam logic signed [StickW-1:0] StickHalf = 10'sd128;

  // direction bit positions
  localparam int unsigned DirUp    = 0;
  localparam int unsigned DirDown  = 1;
  localparam int unsigned DirLeft  = 2;
  localparam int unsigned DirRight = 3;

  // register reset values
  localparam logic [FramesW-1:0]  StableFramesRst = 8'd10;
  localparam logic [MarginW-1:0]  StableMarginRst = 15'd133;
  localparam logic [LimitW-1:0]   AccelLimitRst   = 26'd10486;
  localparam logic [LimitW-1:0]   PtrLimitRst     = 26'd52429;
  localparam logic [IdleW-1:0]    IdleLimitRst    = 18'd216000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_STABLE_FRAMES = 3'd0,
    CFG_STABLE_MARGIN = 3'd1,
    CFG_ACCEL_LIMIT   = 3'd2,
    CFG_PTR_LIMIT     = 3'd3,
    CFG_IDLE_LIMIT    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] hold;
    logic [3:0] pressed;
    logic [3:0] released;
  } stick_res_t;

  typedef struct packed {
    logic [NumAxes-1:0]             mask;
    logic [NumAxes-1:0][AccelW-1:0] latched;
    logic [NumAxes-1:0][AccSqW-1:0] acc_sq;
    logic [NumPtr-1:0][PtrSqW-1:0]  ptr_sq;
  } motion_res_t;

endpackage

// ----- hw/rtl/fcond_stick.sv -----
// ----------------------------------------------------------------------------
// fcond_stick
// stick to direction bits, with press and release edges
// ----------------------------------------------------------------------------
module fcond_stick import fcond_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     read_ok_i,
  input  logic                     is_freestyle_i,
  input  logic signed [StickW-1:0] stick_x_i,
  input  logic signed [StickW-1:0] stick_y_i,
  output stick_res_t               res_o
);

  logic [3:0] last_q;
  logic [3:0] now_bits;

  always_comb begin
    now_bits = '0;
    if (is_freestyle_i) begin
      if (stick_x_i <= -StickHalf) begin
        now_bits[DirLeft] = 1'b1;
      end else if (stick_x_i >= StickHalf) begin
        now_bits[DirRight] = 1'b1;
      end
      if (stick_y_i <= -StickHalf) begin
        now_bits[DirDown] = 1'b1;
      end else if (stick_y_i >= StickHalf) begin
        now_bits[DirUp] = 1'b1;
      end
    end
  end

  always_comb begin
    if (read_ok_i) begin
      res_o.hold     = now_bits;
      res_o.pressed  = now_bits & ~last_q;
      res_o.released = last_q & ~now_bits;
    end else begin
      res_o.hold     = last_q;
      res_o.pressed  = '0;
      res_o.released = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (en_i && read_ok_i) begin
      last_q <= now_bits;
    end
  end

endmodule

// ----- hw/rtl/fcond_motion.sv -----
// ----------------------------------------------------------------------------
// fcond_motion
// per-axis stability tracking and squared frame-to-frame changes
// ----------------------------------------------------------------------------
module fcond_motion import fcond_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [NumAxes-1:0][AccelW-1:0]   accel_i,
  input  logic [NumPtr-1:0][PtrW-1:0]      pointer_i,
  input  logic [FramesW-1:0]               stable_frames_i,
  input  logic [MarginW-1:0]               stable_margin_i,
  output motion_res_t                      res_o
);

  logic [FramesW-1:0]       calm_q    [NumAxes];
  logic [FramesW-1:0]       calm_d    [NumAxes];
  logic [AccelW-1:0]        latched_q [NumAxes];
  logic [AccelW-1:0]        prev_acc_q[NumAxes];
  logic [PtrW-1:0]          prev_ptr_q[NumPtr];

  logic signed [AccelW:0]   acc_diff  [NumAxes];
  logic signed [2*AccelW+1:0] acc_prod[NumAxes];
  logic signed [PtrW:0]     ptr_diff  [NumPtr];
  logic signed [2*PtrW+1:0] ptr_prod  [NumPtr];
  logic [FramesW:0]         calm_inc  [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      acc_diff[i] = $signed({accel_i[i][AccelW-1], accel_i[i]})
                  - $signed({prev_acc_q[i][AccelW-1], prev_acc_q[i]});
      acc_prod[i] = acc_diff[i] * acc_diff[i];
      res_o.acc_sq[i] = acc_prod[i][AccSqW-1:0];
      calm_inc[i] = {1'b0, calm_q[i]} + 1'b1;
      res_o.mask[i]    = 1'b0;
      res_o.latched[i] = latched_q[i];
      if (acc_diff[i] < $signed({2'b00, stable_margin_i})) begin
        if (calm_inc[i] >= {1'b0, stable_frames_i}) begin
          calm_d[i]        = stable_frames_i;
          res_o.mask[i]    = 1'b1;
          res_o.latched[i] = accel_i[i];
        end else begin
          calm_d[i] = calm_inc[i][FramesW-1:0];
        end
      end else begin
        calm_d[i] = '0;
      end
    end
    for (int j = 0; j < NumPtr; j++) begin
      ptr_diff[j] = $signed({pointer_i[j][PtrW-1], pointer_i[j]})
                  - $signed({prev_ptr_q[j][PtrW-1], prev_ptr_q[j]});
      ptr_prod[j] = ptr_diff[j] * ptr_diff[j];
      res_o.ptr_sq[j] = ptr_prod[j][PtrSqW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        calm_q[i]     <= '0;
        latched_q[i]  <= '0;
        prev_acc_q[i] <= '0;
      end
      for (int j = 0; j < NumPtr; j++) begin
        prev_ptr_q[j] <= '0;
      end
    end else if (en_i) begin
      for (int i = 0; i < NumAxes; i++) begin
        calm_q[i]     <= calm_d[i];
        latched_q[i]  <= res_o.latched[i];
        prev_acc_q[i] <= accel_i[i];
      end
      for (int j = 0; j < NumPtr; j++) begin
        prev_ptr_q[j] <= pointer_i[j];
      end
    end
  end

endmodule

// ----- hw/rtl/fcond_idle.sv -----
// ----------------------------------------------------------------------------
// fcond_idle
// activity decision and saturating idle frame counter
// ----------------------------------------------------------------------------
module fcond_idle import fcond_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             busy_i,
  input  logic [NumAxes-1:0][AccSqW-1:0]   acc_sq_i,
  input  logic [NumPtr-1:0][PtrSqW-1:0]    ptr_sq_i,
  input  logic [LimitW-1:0]                accel_limit_i,
  input  logic [LimitW-1:0]                ptr_limit_i,
  input  logic [IdleW-1:0]                 idle_limit_i,
  output logic [IdleW-1:0]                 idle_count_o
);

  localparam int unsigned AccSumW = AccSqW + 2;
  localparam int unsigned PtrSumW = PtrSqW + 2;

  logic [AccSumW-1:0] acc_sum;
  logic [PtrSumW-1:0] ptr_sum;
  logic               active;
  logic [IdleW-1:0]   idle_q;
  logic [IdleW-1:0]   idle_d;

  always_comb begin
    acc_sum = AccSumW'(acc_sq_i[0]) + AccSumW'(acc_sq_i[1]) + AccSumW'(acc_sq_i[2]);
    ptr_sum = PtrSumW'(ptr_sq_i[0]) + PtrSumW'(ptr_sq_i[1]);
    active  = busy_i
           || (acc_sum > AccSumW'(accel_limit_i))
           || (ptr_sum > PtrSumW'(ptr_limit_i));
    if (active) begin
      idle_d = '0;
    end else if (idle_q < idle_limit_i) begin
      idle_d = idle_q + 1'b1;
    end else begin
      idle_d = idle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= '0;
    end else if (en_i) begin
      idle_q <= idle_d;
    end
  end

  // holds the count of the item in the result register
  assign idle_count_o = idle_q;

endmodule

// ----- hw/rtl/controller_frame_conditioner.sv -----
// ----------------------------------------------------------------------------
// controller_frame_conditioner
// per-frame stick decoding, accel stability latch and idle frame counting
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------
//  s_axis    | in        | tvalid / tready       | tdata 112b, tuser 2b flags
//  m_axis    | out       | tvalid / tready       | tdata 88b
//  cfg       | in        | cfg_we_i, no wait     | cfg_addr_i, cfg_wdata_i
//
//  one frame per cycle sustained while m_axis_tready is high; a frame passes
//  the input register, compute register and result register on its way out
//  the squares of the accel and pointer changes are registered in the compute
//  stage so the sum and limit compare sit in the result stage of their own
//  each stage has its own valid bit, so a stalled result only blocks the input
//  once every stage behind it is full
//  reset clears all history, the idle counter and the config registers
//  to their defaults; no clearing pass
//
module controller_frame_conditioner import fcond_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input frames
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // stick_x, stick_y, accel_x, accel_y, accel_z, pointer_x, pointer_y,
  // buttons_held, 4 zero bits
  input  logic [111:0]        s_axis_tdata,
  // read_ok, is_freestyle
  input  logic [1:0]          s_axis_tuser,
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // stick_hold, stick_press, stick_release, stable_mask, stable_accel_x,
  // stable_accel_y, stable_accel_z, idle_frames, 7 zero bits
  output logic [87:0]         m_axis_tdata,
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [FramesW-1:0] stable_frames_q;
  logic [MarginW-1:0] stable_margin_q;
  logic [LimitW-1:0]  accel_limit_q;
  logic [LimitW-1:0]  ptr_limit_q;
  logic [IdleW-1:0]   idle_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_frames_q <= StableFramesRst;
      stable_margin_q <= StableMarginRst;
      accel_limit_q   <= AccelLimitRst;
      ptr_limit_q     <= PtrLimitRst;
      idle_limit_q    <= IdleLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_STABLE_FRAMES: stable_frames_q <= cfg_wdata_i[FramesW-1:0];
        CFG_STABLE_MARGIN: stable_margin_q <= cfg_wdata_i[MarginW-1:0];
        CFG_ACCEL_LIMIT:   accel_limit_q   <= cfg_wdata_i[LimitW-1:0];
        CFG_PTR_LIMIT:     ptr_limit_q     <= cfg_wdata_i[LimitW-1:0];
        CFG_IDLE_LIMIT:    idle_limit_q    <= cfg_wdata_i[IdleW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage control: each stage moves when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic in_vld_q, mid_vld_q, out_vld_q;
  logic in_rdy, mid_rdy, out_rdy;
  logic in_load, mid_load, out_load;

  assign out_rdy  = !out_vld_q || m_axis_tready;
  assign mid_rdy  = !mid_vld_q || out_rdy;
  assign in_rdy   = !in_vld_q  || mid_rdy;

  assign in_load  = s_axis_tvalid && in_rdy;
  assign mid_load = in_vld_q && mid_rdy;   // frame processed, history updated
  assign out_load = mid_vld_q && out_rdy;  // idle counter updated

  assign s_axis_tready = in_rdy;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_rdy)  in_vld_q  <= s_axis_tvalid;
      if (mid_rdy) mid_vld_q <= in_vld_q;
      if (out_rdy) out_vld_q <= mid_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                             read_ok_q;
  logic                             is_freestyle_q;
  logic signed [StickW-1:0]         stick_x_q;
  logic signed [StickW-1:0]         stick_y_q;
  logic [NumAxes-1:0][AccelW-1:0]   accel_q;
  logic [NumPtr-1:0][PtrW-1:0]      pointer_q;
  logic [ButtonsW-1:0]              buttons_q;

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      read_ok_q      <= s_axis_tuser[0];
      is_freestyle_q <= s_axis_tuser[1];
      stick_x_q      <= $signed(s_axis_tdata[9:0]);
      stick_y_q      <= $signed(s_axis_tdata[19:10]);
      accel_q[0]     <= s_axis_tdata[35:20];
      accel_q[1]     <= s_axis_tdata[51:36];
      accel_q[2]     <= s_axis_tdata[67:52];
      pointer_q[0]   <= s_axis_tdata[79:68];
      pointer_q[1]   <= s_axis_tdata[91:80];
      buttons_q      <= s_axis_tdata[107:92];
    end
  end

  // --------------------------------------------------------------------------
  // compute stage: stick decode, stability, squared changes
  // --------------------------------------------------------------------------
  stick_res_t  stick_res;
  motion_res_t motion_res;

  fcond_stick u_stick (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (mid_load),
    .read_ok_i      (read_ok_q),
    .is_freestyle_i (is_freestyle_q),
    .stick_x_i      (stick_x_q),
    .stick_y_i      (stick_y_q),
    .res_o          (stick_res)
  );

  fcond_motion u_motion (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (mid_load),
    .accel_i         (accel_q),
    .pointer_i       (pointer_q),
    .stable_frames_i (stable_frames_q),
    .stable_margin_i (stable_margin_q),
    .res_o           (motion_res)
  );

  stick_res_t  mid_stick_q;
  motion_res_t mid_motion_q;
  logic        mid_busy_q;   // button held or a stick direction held

  always_ff @(posedge clk_i) begin
    if (mid_load) begin
      mid_stick_q  <= stick_res;
      mid_motion_q <= motion_res;
      mid_busy_q   <= (buttons_q != '0) || (stick_res.hold != '0);
    end
  end

  // --------------------------------------------------------------------------
  // result stage: activity compare and idle counter
  // --------------------------------------------------------------------------
  logic [IdleW-1:0] idle_count;

  fcond_idle u_idle (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (out_load),
    .busy_i        (mid_busy_q),
    .acc_sq_i      (mid_motion_q.acc_sq),
    .ptr_sq_i      (mid_motion_q.ptr_sq),
    .accel_limit_i (accel_limit_q),
    .ptr_limit_i   (ptr_limit_q),
    .idle_limit_i  (idle_limit_q),
    .idle_count_o  (idle_count)
  );

  stick_res_t                     out_stick_q;
  logic [NumAxes-1:0]             out_mask_q;
  logic [NumAxes-1:0][AccelW-1:0] out_latched_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stick_q   <= mid_stick_q;
      out_mask_q    <= mid_motion_q.mask;
      out_latched_q <= mid_motion_q.latched;
    end
  end

  // idle_count only moves when the result register loads
  assign m_axis_tdata = {7'b0, idle_count,
                         out_latched_q[2], out_latched_q[1], out_latched_q[0],
                         out_mask_q, out_stick_q.released, out_stick_q.pressed,
                         out_stick_q.hold};

endmodule

// ----- hw/rtl/fcond_checker.sv -----
// ----------------------------------------------------------------------------
// fcond_checker
// port-level checks on the result channel of the frame conditioner
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcond_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [87:0] out_data_i
);

  logic [3:0] hold;
  logic [3:0] pressed;
  logic [3:0] released;
  logic       edges_overlap;
  logic       edges_off_hold;
  logic       opposites_held;
  logic       stalled;

  assign hold     = out_data_i[3:0];
  assign pressed  = out_data_i[7:4];
  assign released = out_data_i[11:8];

  assign edges_overlap  = (pressed & released) != 4'b0;
  assign edges_off_hold = ((pressed & ~hold) != 4'b0) || ((released & hold) != 4'b0);
  assign opposites_held = (hold[0] && hold[1]) || (hold[2] && hold[3]);
  assign stalled        = out_valid_i && !out_ready_i;

  // a direction cannot be pressed and released in the same frame
  `FCOND_ASSERT_IMPL(a_edges_disjoint, out_valid_i, !edges_overlap, "press and release overlap")

  // a press shows in the held bits, a release does not
  `FCOND_ASSERT_IMPL(a_edges_vs_hold, out_valid_i, !edges_off_hold, "edges disagree with hold")

  // opposite directions never held together
  `FCOND_ASSERT_IMPL(a_no_opposites, out_valid_i, !opposites_held, "opposite directions held")

  // stalled result stays put
  `FCOND_ASSERT(a_stall_hold, stalled |=> out_valid_i && $stable(out_data_i), "stall moved data")

endmodule

bind controller_frame_conditioner fcond_checker u_fcond_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (m_axis_tvalid),
  .out_ready_i (m_axis_tready),
  .out_data_i  (m_axis_tdata)
);
